@@ src/acde_pkg.sv @@
// Shared codes, widths, defaults and control/status bundles for the drift estimator.
package acde_pkg;

    localparam int FRAC_BITS_DEF = 40;

    // Field and register widths
    localparam int FUNC_W     = 2;
    localparam int STAMP_W    = 32;
    localparam int ADJ_W      = 8;
    localparam int RATIO_W    = 29;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int SYS_CLK_W  = 30;
    localparam int RATE_W     = 18;
    localparam int CFG_W      = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDE_W     = 64;
    localparam int PROD_W     = STAMP_W + SYS_CLK_W;
    localparam int CNT_W      = 7;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FN_EVAL    = 2'd2;

    // Source modes
    localparam logic [MODE_W-1:0] MODE_USB    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_APPLY  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOMEAS = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYS_CLK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_RATE  = 2'd2;

    // Register reset values
    localparam logic [MODE_W-1:0]    MODE_RST    = MODE_USB;
    localparam logic [SYS_CLK_W-1:0] SYS_CLK_RST = 30'd96000000;
    localparam logic [RATE_W-1:0]    RATE_RST    = 18'd48000;

    // Divider length and the millisecond-frame divisor
    localparam int RATE_DIV_BITS  = PROD_W;
    localparam int KHZ            = 1000;

    // floor(x / 1000) = (x * KHZ_RECIP) >> KHZ_SHIFT, exact for any 30-bit x
    localparam int KHZ_RECIP_W = 29;
    localparam int KHZ_PROD_W  = SYS_CLK_W + KHZ_RECIP_W;
    localparam int KHZ_SHIFT   = 38;
    localparam logic [KHZ_RECIP_W-1:0] KHZ_RECIP = 29'd274877907;

    typedef enum logic {
        DIV_RATE,
        DIV_FRAC
    } div_sel_t;

    typedef struct packed {
        logic     tick;
        logic     restart;
        logic     eval;
        logic     local_ld;
        logic     set_nomeas;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_step;
        logic     mul_ld;
        logic     src_ld;
        logic     diff_ld;
        logic     sat_ld;
        logic     sum_ld;
        logic     lim_ld;
        logic     out_ld;
    } acde_cmd_t;

    typedef struct packed {
        logic              pending;
        logic [MODE_W-1:0] mode;
        logic              rate_zero;
        logic              div_last;
        logic              src_zero;
        logic              local_zero;
        logic              mag_ge_local;
        logic              out_free;
    } acde_sts_t;

endpackage

@@ src/acde_ctrl.sv @@
// Sequencer for request decode and the evaluate sequence of the drift estimator.
module acde_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [acde_pkg::FUNC_W-1:0]         s_func,
    input  acde_pkg::acde_sts_t                 sts,
    output acde_pkg::acde_cmd_t                 cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOCAL,
        ST_MUL,
        ST_RATE_START,
        ST_RATE_DIV,
        ST_SRC,
        ST_DIFF,
        ST_SAT,
        ST_FRAC_DIV,
        ST_SUM,
        ST_LIMIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_func)
                        acde_pkg::FN_TICK: begin
                            cmd.tick = (sts.mode == acde_pkg::MODE_USB) ||
                                       (sts.mode == acde_pkg::MODE_SAMPLE);
                        end
                        acde_pkg::FN_RESTART: begin
                            cmd.restart = 1'b1;
                        end
                        acde_pkg::FN_EVAL: begin
                            cmd.eval   = 1'b1;
                            state_next = ST_LOCAL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOCAL: begin
                cmd.local_ld = 1'b1;
                if (sts.pending) begin
                    cmd.set_nomeas = 1'b1;
                    state_next     = ST_OUT;
                end else if (sts.mode == acde_pkg::MODE_USB) begin
                    state_next = ST_MUL;
                end else if (sts.mode == acde_pkg::MODE_SAMPLE && !sts.rate_zero) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.set_nomeas = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.mul_ld = 1'b1;
                if (sts.mode == acde_pkg::MODE_USB) begin
                    state_next = ST_SRC;
                end else begin
                    state_next = ST_RATE_START;
                end
            end
            ST_RATE_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = acde_pkg::DIV_RATE;
                state_next    = ST_RATE_DIV;
            end
            ST_RATE_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SRC;
                end
            end
            ST_SRC: begin
                cmd.src_ld = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                if (sts.src_zero || sts.local_zero) begin
                    cmd.set_nomeas = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd.diff_ld = 1'b1;
                    state_next  = ST_SAT;
                end
            end
            ST_SAT: begin
                if (sts.mag_ge_local) begin
                    cmd.sat_ld = 1'b1;
                    state_next = ST_SUM;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = acde_pkg::DIV_FRAC;
                    state_next    = ST_FRAC_DIV;
                end
            end
            ST_FRAC_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_ld = 1'b1;
                state_next = ST_LIMIT;
            end
            ST_LIMIT: begin
                cmd.lim_ld = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold the result until the output slot frees up
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> sts.out_free)
        else $error("result loaded into a busy output slot");

    a_div_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> cmd.div_step)
        else $error("divider loaded but not stepped");

    a_div_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && sts.div_last) |=> !cmd.div_step)
        else $error("divider stepped past its last bit");
`endif

endmodule

@@ src/acde_dp.sv @@
// Datapath: stamp extension, tick counting, shared bit-serial divider and ratio limits.
module acde_dp #(
    parameter int FRAC_BITS = acde_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [acde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acde_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [acde_pkg::STAMP_W-1:0]        in_stamp,
    input  logic signed [acde_pkg::ADJ_W-1:0]   in_adjust,
    input  acde_pkg::acde_cmd_t                 cmd,
    output acde_pkg::acde_sts_t                 sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acde_pkg::RATIO_W-1:0]        m_ratio,
    output logic [acde_pkg::STATUS_W-1:0]       m_status
);

    localparam int W  = acde_pkg::WIDE_W;
    localparam int RW = FRAC_BITS + 4;
    localparam int QW = FRAC_BITS + 2;
    localparam int KQ = acde_pkg::KHZ_PROD_W - acde_pkg::KHZ_SHIFT;

    localparam longint unsigned STEP_Q =
        ((64'd3 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
    localparam longint unsigned LIMIT_Q = (64'd150 << FRAC_BITS) / 64'd1000000;
    localparam longint unsigned DEAD_Q  = (64'd11 << FRAC_BITS) / 64'd10000000000;

    localparam logic signed [RW-1:0] STEP_S  = RW'(STEP_Q);
    localparam logic [RW-1:0]        LIMIT_V = RW'(LIMIT_Q);
    localparam logic [RW-1:0]        DEAD_V  = RW'(DEAD_Q);
    localparam logic [QW-1:0]        SAT_V   = {1'b1, {(FRAC_BITS + 1){1'b0}}};

    // configuration
    logic [acde_pkg::MODE_W-1:0]    mode_reg;
    logic [acde_pkg::SYS_CLK_W-1:0] sys_clk_reg;
    logic [acde_pkg::RATE_W-1:0]    rate_reg;

    // measurement state
    logic                           pending_reg;
    logic [acde_pkg::STAMP_W-1:0]   start_reg;
    logic [acde_pkg::STAMP_W-1:0]   latest_reg;
    logic [acde_pkg::STAMP_W-1:0]   wrap_reg;
    logic [acde_pkg::STAMP_W-1:0]   ticks_reg;

    // evaluate working registers
    logic signed [acde_pkg::ADJ_W-1:0] adj_reg;
    logic [W-1:0]                   local_reg;
    logic [acde_pkg::SYS_CLK_W-1:0] scale_reg;
    logic [acde_pkg::PROD_W-1:0]    prod_reg;
    logic [W-1:0]                   src_reg;
    logic                           neg_reg;
    logic [W-1:0]                   mag_reg;
    logic                           sat_reg;
    logic signed [RW-1:0]           r_reg;
    logic [acde_pkg::RATIO_W-1:0]   res_ratio_reg;
    logic [acde_pkg::STATUS_W-1:0]  res_status_reg;

    // divider
    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   quo_reg;
    logic [W-1:0]                   den_reg;
    logic [acde_pkg::CNT_W-1:0]     cnt_reg;

    // output slot
    logic                           m_valid_reg;
    logic [acde_pkg::RATIO_W-1:0]   m_ratio_reg;
    logic [acde_pkg::STATUS_W-1:0]  m_status_reg;

    logic [W:0]                     div_shift;
    logic                           div_ge;
    logic [W:0]                     div_sub;
    logic [acde_pkg::KHZ_PROD_W-1:0] khz_p;
    logic [acde_pkg::SYS_CLK_W-1:0] scale_next;
    logic [acde_pkg::SYS_CLK_W-1:0] mul_b;
    logic [acde_pkg::PROD_W-1:0]    mul_p;
    logic [W-1:0]                   local_next;
    logic [W-1:0]                   src_next;
    logic [W-1:0]                   diff_sl;
    logic [W-1:0]                   diff_ls;
    logic [QW-1:0]                  qmag;
    logic signed [RW-1:0]           qmag_s;
    logic signed [RW-1:0]           raw;
    logic signed [RW-1:0]           adj_ext;
    logic signed [RW-1:0]           r_next;
    logic [RW-1:0]                  abs_r;
    logic                           out_free;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign div_shift = {rem_reg, quo_reg[W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_sub   = div_shift - {1'b0, den_reg};

    // cycles per millisecond frame by reciprocal multiply
    assign khz_p      = acde_pkg::KHZ_PROD_W'(sys_clk_reg) *
                        acde_pkg::KHZ_PROD_W'(acde_pkg::KHZ_RECIP);
    assign scale_next = {{(acde_pkg::SYS_CLK_W - KQ){1'b0}},
                         khz_p[acde_pkg::KHZ_PROD_W-1:acde_pkg::KHZ_SHIFT]};

    // millisecond frames scale by cycles per frame, sample counting by the clock itself
    assign mul_b = (mode_reg == acde_pkg::MODE_USB) ? scale_reg : sys_clk_reg;
    assign mul_p = acde_pkg::PROD_W'(ticks_reg) * acde_pkg::PROD_W'(mul_b);

    assign local_next = {wrap_reg, latest_reg} - {{(W - acde_pkg::STAMP_W){1'b0}}, start_reg};
    assign src_next   = (mode_reg == acde_pkg::MODE_USB)
                      ? {{(W - acde_pkg::PROD_W){1'b0}}, prod_reg}
                      : quo_reg;
    assign diff_sl    = src_reg - local_reg;
    assign diff_ls    = local_reg - src_reg;

    assign qmag    = sat_reg ? SAT_V : {2'b00, quo_reg[FRAC_BITS-1:0]};
    assign qmag_s  = signed'({2'b00, qmag});
    assign raw     = neg_reg ? -qmag_s : qmag_s;
    assign adj_ext = {{(RW - acde_pkg::ADJ_W){adj_reg[acde_pkg::ADJ_W-1]}}, adj_reg};
    assign r_next  = raw + adj_ext * STEP_S;
    assign abs_r   = r_reg[RW-1] ? unsigned'(-r_reg) : unsigned'(r_reg);

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        sts              = '0;
        sts.pending      = pending_reg;
        sts.mode         = mode_reg;
        sts.rate_zero    = (rate_reg == '0);
        sts.div_last     = (cnt_reg == acde_pkg::CNT_W'(1));
        sts.src_zero     = (src_reg == '0);
        sts.local_zero   = (local_reg == '0);
        sts.mag_ge_local = (mag_reg >= local_reg);
        sts.out_free     = out_free;
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= acde_pkg::MODE_RST;
            sys_clk_reg <= acde_pkg::SYS_CLK_RST;
            rate_reg    <= acde_pkg::RATE_RST;
            pending_reg <= 1'b0;
            start_reg   <= '0;
            latest_reg  <= '0;
            wrap_reg    <= '0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    acde_pkg::REG_SOURCE_MODE: mode_reg    <= cfg_wdata[acde_pkg::MODE_W-1:0];
                    acde_pkg::REG_SYS_CLK:     sys_clk_reg <= cfg_wdata[acde_pkg::SYS_CLK_W-1:0];
                    acde_pkg::REG_AUDIO_RATE:  rate_reg    <= cfg_wdata[acde_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.tick) begin
                if (pending_reg) begin
                    // first tick after a restart opens the window
                    pending_reg <= 1'b0;
                    start_reg   <= in_stamp;
                    latest_reg  <= in_stamp;
                    wrap_reg    <= '0;
                    ticks_reg   <= '0;
                end else begin
                    if (in_stamp < latest_reg) begin
                        wrap_reg <= wrap_reg + acde_pkg::STAMP_W'(1);
                    end
                    latest_reg <= in_stamp;
                    ticks_reg  <= ticks_reg + acde_pkg::STAMP_W'(1);
                end
            end
            if (cmd.restart || cmd.out_ld) begin
                pending_reg <= 1'b1;
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // evaluate payload
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            adj_reg <= in_adjust;
        end
        if (cmd.local_ld) begin
            local_reg <= local_next;
            scale_reg <= scale_next;
        end
        if (cmd.mul_ld) begin
            prod_reg <= mul_p;
        end
        if (cmd.src_ld) begin
            src_reg <= src_next;
        end
        if (cmd.diff_ld) begin
            neg_reg <= (src_reg < local_reg);
            mag_reg <= (src_reg < local_reg) ? diff_ls : diff_sl;
        end
        if (cmd.sat_ld) begin
            sat_reg <= 1'b1;
        end
        if (cmd.div_start) begin
            case (cmd.div_sel)
                acde_pkg::DIV_RATE: begin
                    rem_reg <= '0;
                    quo_reg <= {prod_reg, {(W - acde_pkg::PROD_W){1'b0}}};
                    den_reg <= {{(W - acde_pkg::RATE_W){1'b0}}, rate_reg};
                    cnt_reg <= acde_pkg::CNT_W'(acde_pkg::RATE_DIV_BITS);
                end
                default: begin
                    rem_reg <= mag_reg;
                    quo_reg <= '0;
                    den_reg <= local_reg;
                    cnt_reg <= acde_pkg::CNT_W'(FRAC_BITS);
                    sat_reg <= 1'b0;
                end
            endcase
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? div_sub[W-1:0] : div_shift[W-1:0];
            quo_reg <= {quo_reg[W-2:0], div_ge};
            cnt_reg <= cnt_reg - acde_pkg::CNT_W'(1);
        end
        if (cmd.sum_ld) begin
            r_reg <= r_next;
        end
        if (cmd.set_nomeas) begin
            res_status_reg <= acde_pkg::STAT_NOMEAS;
            res_ratio_reg  <= '0;
        end else if (cmd.lim_ld) begin
            if (abs_r > LIMIT_V) begin
                res_status_reg <= acde_pkg::STAT_RANGE;
                res_ratio_reg  <= '0;
            end else begin
                res_status_reg <= acde_pkg::STAT_APPLY;
                // drop results inside the deadband
                res_ratio_reg  <= (abs_r <= DEAD_V) ? '0 : r_reg[acde_pkg::RATIO_W-1:0];
            end
        end
        if (cmd.out_ld) begin
            m_ratio_reg  <= res_ratio_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_ratio  = m_ratio_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    a_step_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (cnt_reg != '0))
        else $error("divider stepped with no bits left");

    a_restart_after_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |=> pending_reg)
        else $error("evaluate did not restart the measurement");

    a_reject_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != acde_pkg::STAT_APPLY)) |-> (m_ratio_reg == '0))
        else $error("rejected result carries a nonzero ratio");
`endif

endmodule

@@ src/audio_clock_drift_estimator.sv @@
// Top level of the audio clock drift estimator: sequencer plus datapath.
//
//  channel | ports            | contents
//  --------+------------------+------------------------------------------------
//  input   | s_tvalid/tready  | tuser: func; tdata: local_count, buffer_adjust
//  result  | m_tvalid/tready  | tuser: status; tdata: drift_ratio
//  config  | cfg_we/index     | cfg_wdata: source_mode, sys_clk_hz, audio_rate
//
// Tick and restart requests leave the block ready for the next request. An
// evaluate request runs through the sequencer states and uses the
// one-bit-per-cycle shared divider for the sample-rate divide in sample mode and for
// the fraction divide; a saturated ratio skips the fraction divide, and an evaluate
// with no open window, no usable mode or a zero sample rate goes straight to the
// output state. Reset is synchronous; a held result in the output register stalls
// only the end of the next evaluate.
module audio_clock_drift_estimator #(
    parameter int FRAC_BITS = acde_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // local_count, buffer_adjust
    input  logic [1:0]                      s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // drift_ratio
    output logic [1:0]                      m_tuser,   // status
    input  logic                            cfg_we,
    input  logic [acde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acde_pkg::CFG_W-1:0]      cfg_wdata
);

    acde_pkg::acde_cmd_t                cmd;
    acde_pkg::acde_sts_t                sts;
    logic [acde_pkg::RATIO_W-1:0]       ratio;
    logic [acde_pkg::STATUS_W-1:0]      status;

    acde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    acde_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_stamp  (s_tdata[31:0]),
        .in_adjust (signed'(s_tdata[39:32])),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_ratio   (ratio),
        .m_status  (status)
    );

    assign m_tdata = {{(32 - acde_pkg::RATIO_W){1'b0}}, ratio};
    assign m_tuser = status;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the audio clock drift estimator: scoreboard, stream drivers, stimulus.
module testbench;
    import acde_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 150;
    localparam int ITEM_TARGET  = 525;

    typedef struct packed {
        logic [31:0]         ratio;
        logic [STATUS_W-1:0] status;
    } ratio_result_t;

    class ratio_tracker;
        localparam int FB = FRAC_BITS_DEF;
        localparam longint unsigned STEP_Q  = ((64'd3 << FB) + 64'd5000000) / 64'd10000000;
        localparam longint unsigned LIMIT_Q = (64'd150 << FB) / 64'd1000000;
        localparam longint unsigned DEAD_Q  = (64'd11 << FB) / 64'd10000000000;
        localparam longint unsigned SAT_Q   = 64'd1 << (FB + 1);

        logic [MODE_W-1:0]    mode;
        logic [SYS_CLK_W-1:0] sys_clk;
        logic [RATE_W-1:0]    rate;
        bit                   pending;
        bit [31:0]            start_stamp;
        bit [31:0]            latest_stamp;
        bit [31:0]            wrap_cnt;
        bit [31:0]            tick_cnt;
        ratio_result_t        expected_ratios[$];
        int                   mismatches;

        function new();
            mode         = MODE_RST;
            sys_clk      = SYS_CLK_RST;
            rate         = RATE_RST;
            pending      = 1'b0;
            start_stamp  = '0;
            latest_stamp = '0;
            wrap_cnt     = '0;
            tick_cnt     = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SOURCE_MODE: mode = data[MODE_W-1:0];
                REG_SYS_CLK:     sys_clk = data[SYS_CLK_W-1:0];
                REG_AUDIO_RATE:  rate = data[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        function ratio_result_t predict_ratio(logic signed [ADJ_W-1:0] adj);
            ratio_result_t   res;
            longint unsigned span, src, mag, qmag, rem;
            longint          raw, r, absr;
            bit              carry, neg;
            res.ratio  = '0;
            res.status = STAT_NOMEAS;
            if (pending)
                return res;
            span = {wrap_cnt, latest_stamp} - {32'd0, start_stamp};
            case (mode)
                MODE_USB:    src = 64'(tick_cnt) * (64'(sys_clk) / KHZ);
                MODE_SAMPLE: src = (rate != 0) ? (64'(tick_cnt) * 64'(sys_clk)) / 64'(rate) : 64'd0;
                default:     src = 64'd0;
            endcase
            if (src == 0 || span == 0)
                return res;
            neg = src < span;
            mag = neg ? span - src : src - span;
            if (mag >= span) begin
                qmag = SAT_Q;
            end else begin
                // restoring division, one quotient bit per step
                rem  = mag;
                qmag = 0;
                for (int i = 0; i < FB; i++) begin
                    carry = rem[63];
                    rem   = rem << 1;
                    qmag  = qmag << 1;
                    if (carry || rem >= span) begin
                        rem     = rem - span;
                        qmag[0] = 1'b1;
                    end
                end
            end
            raw  = neg ? -longint'(qmag) : longint'(qmag);
            r    = raw + longint'(adj) * longint'(STEP_Q);
            absr = (r < 0) ? -r : r;
            if (absr > longint'(LIMIT_Q)) begin
                res.status = STAT_RANGE;
                return res;
            end
            if (absr <= longint'(DEAD_Q))
                r = 0;
            res.ratio  = {3'b000, r[RATIO_W-1:0]};
            res.status = STAT_APPLY;
            return res;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [STAMP_W-1:0] stamp,
                                   logic signed [ADJ_W-1:0] adj);
            case (func)
                FN_TICK: begin
                    if (mode == MODE_USB || mode == MODE_SAMPLE) begin
                        if (pending) begin
                            pending      = 1'b0;
                            start_stamp  = stamp;
                            latest_stamp = stamp;
                            wrap_cnt     = '0;
                            tick_cnt     = '0;
                        end else begin
                            if (stamp < latest_stamp)
                                wrap_cnt = wrap_cnt + 1;
                            latest_stamp = stamp;
                            tick_cnt     = tick_cnt + 1;
                        end
                    end
                end
                FN_RESTART: pending = 1'b1;
                FN_EVAL: begin
                    expected_ratios.push_back(predict_ratio(adj));
                    pending = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [31:0] ratio, logic [STATUS_W-1:0] status);
            ratio_result_t want;
            if (expected_ratios.size() == 0) begin
                report($sformatf("unexpected result ratio %h status %0d", ratio, status));
                return;
            end
            want = expected_ratios.pop_front();
            if (ratio !== want.ratio)
                report($sformatf("drift_ratio %h, want %h", ratio, want.ratio));
            if (status !== want.status)
                report($sformatf("status %0d, want %0d", status, want.status));
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // local_count, buffer_adjust
    logic [1:0]           s_tuser   = '0;   // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // drift_ratio
    logic [1:0]           m_tuser;          // status
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    ratio_tracker tracker = new();

    int                   cycles      = 0;
    int                   rdy_run     = 0;
    int                   burst_left  = 0;
    int                   max_gap     = 4;
    int                   items_sent  = 0;
    bit                   sending     = 1'b0;
    logic [MODE_W-1:0]    cur_mode    = MODE_RST;
    logic [SYS_CLK_W-1:0] cur_clk     = SYS_CLK_RST;
    logic [RATE_W-1:0]    cur_rate    = RATE_RST;

    audio_clock_drift_estimator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                tracker.set_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                tracker.note_request(s_tuser, s_tdata[31:0], s_tdata[39:32]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
        end
    end

    // Result side: alternate ready and stall runs, now and then a long ready stretch.
    always @(posedge aclk) begin
        if (rdy_run > 0) begin
            rdy_run--;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rdy_run = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
            rdy_run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 12);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [STAMP_W-1:0] stamp,
                             input logic [ADJ_W-1:0] adj);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {adj, stamp};
        sending = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (func != FN_UNUSED)
            items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                sending = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Hold off until every result is back and the block has settled.
    task automatic idle_wait();
        if (sending) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
        do @(posedge aclk); while (tracker.expected_ratios.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [SYS_CLK_W-1:0] clk,
                              input logic [RATE_W-1:0] rate);
        write_reg(REG_SOURCE_MODE, CFG_W'(mode));
        write_reg(REG_SYS_CLK, CFG_W'(clk));
        write_reg(REG_AUDIO_RATE, CFG_W'(rate));
        cur_mode = mode;
        cur_clk  = clk;
        cur_rate = rate;
    endtask

    // Restart, latch a start stamp, advance n ticks at the given clock error, evaluate.
    task automatic run_sequence(input int n, input logic [31:0] start, input longint ppm,
                                input longint skew, input logic [ADJ_W-1:0] adj);
        longint      num, den, cum;
        logic [31:0] stamp;
        if (cur_mode == MODE_USB) begin
            num = cur_clk / KHZ;
            den = 1;
        end else begin
            num = cur_clk;
            den = (cur_rate == 0) ? 1 : cur_rate;
        end
        send_item(FN_RESTART, $urandom, ADJ_W'($urandom));
        for (int k = 0; k <= n; k++) begin
            cum = (k * num * (1000000 + ppm)) / (den * 1000000);
            if (k == n)
                cum += skew;
            stamp = start + cum[31:0];
            send_item(FN_TICK, stamp, ADJ_W'($urandom));
        end
        send_item(FN_EVAL, $urandom, adj);
    endtask

    initial begin
        int phase;
        int phase_end;
        int pick;
        int mode_pick;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // frame mode at reset defaults
        send_item(FN_EVAL, 32'hFFFF_FFFF, 8'h80);
        send_item(FN_UNUSED, 32'h0000_0000, 8'h7F);
        run_sequence(2, 32'hFFFF_FFFF, 0, 0, 8'h7F);
        send_item(FN_EVAL, 32'h0000_0000, 8'h00);
        run_sequence(3, 32'h0000_0000, 0, 0, 8'h80);
        run_sequence(1, $urandom, 300, 0, 8'h00);
        idle_wait();

        // one tick spans about 2^30 stamp counts: deadband and saturation
        set_config(MODE_SAMPLE, 30'h3FFF_FFFF, 18'd1);
        run_sequence(2, $urandom, 0, 1, 8'h00);
        run_sequence(1, $urandom, -999999, 0, 8'h00);
        idle_wait();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: set_config(MODE_USB, 30'd96000000, 18'd48000);
                1: set_config(MODE_USB, 30'd1000, 18'd8000);
                2: set_config(MODE_USB, 30'd999, 18'd192000);
                3: set_config(MODE_SAMPLE, 30'd1000000000, 18'd192000);
                4: set_config(MODE_SAMPLE, 30'd0, 18'd48000);
                5: set_config(MODE_SAMPLE, 30'd48000000, 18'd0);
                6: set_config(MODE_NONE, 30'd96000000, 18'd48000);
                7: set_config(MODE_RSVD, 30'd12288000, 18'h3FFFF);
                8: set_config(MODE_USB, 30'h3FFF_FFFF, 18'd8000);
                9: set_config(MODE_SAMPLE, 30'd24576000, 18'd44100);
                default: begin
                    mode_pick = $urandom_range(0, 9);
                    set_config(mode_pick < 5 ? MODE_USB :
                               mode_pick < 9 ? MODE_SAMPLE :
                               MODE_W'($urandom_range(2, 3)),
                               SYS_CLK_W'($urandom_range(1000000, 1073741823)),
                               RATE_W'($urandom_range(8000, 192000)));
                end
            endcase
            case ($urandom_range(0, 3))
                0: max_gap = 0;
                1: max_gap = 2;
                default: max_gap = 10;
            endcase
            phase_end = items_sent + ((phase < 10) ? 20 : 40);
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    run_sequence(($urandom_range(0, 4) == 0) ? $urandom_range(0, 16)
                                                             : $urandom_range(1, 4),
                                 $urandom,
                                 longint'(($urandom_range(0, 3) == 0)
                                          ? int'($urandom_range(0, 800)) - 400
                                          : int'($urandom_range(0, 280)) - 140),
                                 longint'(($urandom_range(0, 3) == 0)
                                          ? int'($urandom_range(0, 6)) - 3 : 0),
                                 ADJ_W'($urandom));
                end else if (pick == 7) begin
                    // evaluate with nothing latched since the restart
                    send_item(FN_RESTART, $urandom, ADJ_W'($urandom));
                    send_item(FN_EVAL, $urandom, ADJ_W'($urandom));
                end else begin
                    send_item(FUNC_W'($urandom_range(0, 3)), $urandom, ADJ_W'($urandom));
                end
            end
            idle_wait();
            phase++;
        end

        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
src/acde_pkg.sv
src/acde_ctrl.sv
src/acde_dp.sv
src/audio_clock_drift_estimator.sv
verif/testbench.sv
